/* src/pac_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pac_pkg - shared types and constants for the PID angle controller
// Word layouts of the sample and result channels, register indexes and
// the fixed field widths of the datapath.
// ---------------------------------------------------------------------------
package pac_pkg;

  // Field widths
  localparam int AngleW    = 16;
  localparam int SpeedW    = 16;
  localparam int GainW     = 16;
  localparam int IntW      = 24;  // error integral, signed Q16.8
  localparam int IntLimW   = 23;  // integral limit magnitude
  localparam int PwmLimW   = 15;  // drive limit magnitude
  localparam int DriveW    = 16;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 23;  // widest register
  localparam int FracShift = 16;  // common fraction bits of the sum

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_KP      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KI      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KD      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_INT_LIM = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PWM_LIM = 3'd4;

  // Register reset values
  localparam logic [IntLimW-1:0] INT_LIM_RESET = 23'h7F_FFFF;
  localparam logic [PwmLimW-1:0] PWM_LIM_RESET = 15'd7200;

  // Sample word
  typedef struct packed {
    logic signed [AngleW-1:0] angle;
    logic signed [SpeedW-1:0] angular_speed;
    logic                     integrate;
  } sample_t;

  // Result word
  typedef struct packed {
    logic signed [DriveW-1:0] drive;
  } result_t;

endpackage

/* src/pac_stream_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pac_stream_if - valid/ready stream channel
// Carries one word of the given payload type per handshake.
// ---------------------------------------------------------------------------
interface pac_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/pid_angle_controller_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pid_angle_controller_top - positional PID with clamped error integral
// Angle is the error (setpoint zero). The integral accumulates or clears per
// word and is clamped to +/- integral_limit; the drive is
// kp*angle + ki*integral + kd*speed*256 on a Q.16 scale, clamped to
// +/- pwm_limit and truncated toward zero.
//
//   channel   | dir | handshake        | payload
//   ----------+-----+------------------+------------------------------------
//   sample    | in  | valid / ready    | angle, angular_speed, integrate
//   result    | out | valid / ready    | drive
//   cfg       | in  | cfg_we           | cfg_index, cfg_data
//
// Three-stage pipeline: integral update at accept, multiply, sum/clamp into
// the output register; one word per cycle while the result is not stalled.
// The throughput is set by the integral recurrence, one add and clamp.
// Each stage advances when empty or when the stage behind it moves, so a
// stalled result only blocks input once all three stages are full.
// Synchronous reset empties the pipeline, clears the integral and loads
// the register defaults.
// ---------------------------------------------------------------------------
module pid_angle_controller_top
  import pac_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  pac_stream_if.sink          sample,
  pac_stream_if.source        result
);

  localparam int SumW = IntW + GainW + 2;  // three Q.16 terms

  // Configuration registers
  logic signed [GainW-1:0] kp;
  logic signed [GainW-1:0] ki;
  logic signed [GainW-1:0] kd;
  logic [IntLimW-1:0]      integral_limit;
  logic [PwmLimW-1:0]      pwm_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp             <= '0;
      ki             <= '0;
      kd             <= '0;
      integral_limit <= INT_LIM_RESET;
      pwm_limit      <= PWM_LIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KP:      kp             <= cfg_data[GainW-1:0];
        CFG_KI:      ki             <= cfg_data[GainW-1:0];
        CFG_KD:      kd             <= cfg_data[GainW-1:0];
        CFG_INT_LIM: integral_limit <= cfg_data[IntLimW-1:0];
        CFG_PWM_LIM: pwm_limit      <= cfg_data[PwmLimW-1:0];
        default: ;
      endcase
    end
  end

  // Stage valids and flow control
  logic v1, v2, v3;
  logic ready1, ready2, ready3;
  logic in_fire;

  assign ready3  = !v3 || result.ready;
  assign ready2  = !v2 || ready3;
  assign ready1  = !v1 || ready2;
  assign in_fire = sample.valid && ready1;
  assign sample.ready = ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= sample.valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  // Integral update: add first, then clamp to +/- limit
  logic signed [IntW-1:0] error_integral;
  logic signed [IntW-1:0] error_integral_next;
  logic signed [IntW:0]   int_sum;
  logic signed [IntW:0]   int_lim;

  always_comb begin
    int_sum = (IntW + 1)'(error_integral) + (IntW + 1)'(sample.data.angle);
    int_lim = (IntW + 1)'({2'b00, integral_limit});
    if (!sample.data.integrate) begin
      error_integral_next = '0;
    end else if (int_sum > int_lim) begin
      error_integral_next = int_lim[IntW-1:0];
    end else if (int_sum < -int_lim) begin
      error_integral_next = IntW'(-int_lim);
    end else begin
      error_integral_next = int_sum[IntW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_integral <= '0;
    end else if (in_fire) begin
      error_integral <= error_integral_next;
    end
  end

  // Stage 1: captured operands
  logic signed [AngleW-1:0] s1_err;
  logic signed [SpeedW-1:0] s1_spd;
  logic signed [IntW-1:0]   s1_int;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_err <= sample.data.angle;
      s1_spd <= sample.data.angular_speed;
      s1_int <= error_integral_next;
    end
  end

  // Stage 2: the three products
  logic signed [GainW+AngleW-1:0] p_kp;
  logic signed [GainW+IntW-1:0]   p_ki;
  logic signed [GainW+SpeedW-1:0] p_kd;

  always_ff @(posedge clk) begin
    if (v1 && ready2) begin
      p_kp <= kp * s1_err;
      p_ki <= ki * s1_int;
      p_kd <= kd * s1_spd;
    end
  end

  // Stage 3: sum, clamp to +/- pwm_limit, truncate toward zero
  logic signed [SumW-1:0]   sum_all;
  logic signed [SumW-1:0]   sum_lim;
  logic signed [31:0]       clamped;
  logic signed [DriveW-1:0] quot;
  logic signed [DriveW-1:0] drive_next;
  logic signed [DriveW-1:0] drive;

  always_comb begin
    sum_all = SumW'(p_kp) + SumW'(p_ki) + (SumW'(p_kd) <<< 8);
    sum_lim = SumW'({pwm_limit, {FracShift{1'b0}}});
    if (sum_all > sum_lim) begin
      clamped = sum_lim[31:0];
    end else if (sum_all < -sum_lim) begin
      clamped = 32'(-sum_lim);
    end else begin
      clamped = sum_all[31:0];
    end
    quot = clamped[31:FracShift];
    // negative with a fraction left: step back toward zero
    if (clamped[31] && (|clamped[FracShift-1:0])) begin
      drive_next = quot + DriveW'(1);
    end else begin
      drive_next = quot;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && ready3) begin
      drive <= drive_next;
    end
  end

  assign result.valid      = v3;
  assign result.data.drive = drive;

endmodule

/* src/pac_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pac_checker - port-level checks for the PID angle controller
// Watches the sample and result channels only; bound to the top level.
// ---------------------------------------------------------------------------
module pac_checker
  import pac_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DriveW-1:0] drive
);

  // Reset leaves the pipeline empty and ready for a word
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && in_ready))
    else $error("pipeline not empty after reset");

  // Input back-pressure only comes from a stalled output word
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while output is free");

  // Drive magnitude never exceeds the 15-bit limit range
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive != {1'b1, {(DriveW-1){1'b0}}}))
    else $error("drive outside limit range");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(drive)))
    else $error("result word changed while stalled");

endmodule

bind pid_angle_controller_top pac_checker u_pac_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .drive     (result.data.drive)
);

/* bench/tb_pid_angle_controller_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_pid_angle_controller_top - self-checking bench for the PID controller
// A scripted table of register writes and samples covers reset defaults,
// gain and angle extremes, drive and integral saturation, zero limits,
// truncation toward zero and ignored register indexes. Random phases then
// reprogram every register and stream samples with random gaps and
// backpressure. Each accepted sample is run through a bit-exact drive
// predictor; results are checked in order against it or a scripted drive.
// ---------------------------------------------------------------------------
module tb_pid_angle_controller_top;
  import pac_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE       = 10;    // settle margin past the pipeline latency
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 50;
  localparam int STALL_AT     = 120;   // result count that starts the long hold
  localparam int STALL_CYCLES = 60;

  localparam logic [CfgIdxW-1:0] CFG_BAD_LO = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_BAD_HI = 3'd7;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the scripted part: a register write or a sample, with an
  // optional hand-computed drive
  typedef struct packed {
    row_kind_t                kind;
    logic [CfgIdxW-1:0]       idx;
    logic [CfgDataW-1:0]      val;
    sample_t                  smp;
    bit                       known;
    logic signed [DriveW-1:0] drive;
  } script_row_t;

  localparam int SCRIPT_LEN = 39;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // reset gains are zero: drive stays zero
    '{ROW_ITEM, '0, '0, '{16'sh7FFF, 16'sh8000, 1'b1}, 1'b1, 16'sd0},
    '{ROW_ITEM, '0, '0, '{16'sh8000, 16'sh7FFF, 1'b0}, 1'b1, 16'sd0},
    // kp = 1.0 with junk above the gain width
    '{ROW_CFG, CFG_KP, 23'h7F_0100, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{16'sh0500, 16'sh0000, 1'b0}, 1'b1, 16'sd5},
    '{ROW_ITEM, '0, '0, '{-16'sh0180, 16'sh0000, 1'b0}, 1'b1, -16'sd1},  // -1.5 -> -1
    '{ROW_ITEM, '0, '0, '{16'sh7FFF, 16'sh0000, 1'b0}, 1'b1, 16'sd127},
    '{ROW_ITEM, '0, '0, '{16'sh8000, 16'sh0000, 1'b0}, 1'b1, -16'sd128},
    // most negative kp saturates at the reset pwm limit
    '{ROW_CFG, CFG_KP, 23'h00_8000, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{16'sh7FFF, 16'sh0000, 1'b0}, 1'b1, -16'sd7200},
    '{ROW_ITEM, '0, '0, '{16'sh8000, 16'sh0000, 1'b0}, 1'b1, 16'sd7200},
    // widest pwm limit, junk above 15 bits
    '{ROW_CFG, CFG_PWM_LIM, 23'h7F_FFFF, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{16'sh8000, 16'sh0000, 1'b0}, 1'b1, 16'sd16384},
    '{ROW_ITEM, '0, '0, '{16'sh7FFF, 16'sh0000, 1'b0}, 1'b1, -16'sd16383},
    // zero pwm limit forces zero drive
    '{ROW_CFG, CFG_PWM_LIM, 23'h00_0000, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{16'sh7FFF, 16'sh0000, 1'b0}, 1'b1, 16'sd0},
    // derivative term alone, saturating at the negative bound
    '{ROW_CFG, CFG_PWM_LIM, 23'h00_7FFF, '0, 1'b0, '0},
    '{ROW_CFG, CFG_KP, 23'h00_0000, '0, 1'b0, '0},
    '{ROW_CFG, CFG_KD, 23'h00_7FFF, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{16'sh0000, 16'sh8000, 1'b0}, 1'b1, -16'sd32767},
    // zero integral limit pins the integral at zero
    '{ROW_CFG, CFG_KD, 23'h00_0000, '0, 1'b0, '0},
    '{ROW_CFG, CFG_KI, 23'h00_0100, '0, 1'b0, '0},
    '{ROW_CFG, CFG_INT_LIM, 23'h00_0000, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{16'sh7FFF, 16'sh0000, 1'b1}, 1'b1, 16'sd0},
    // integral limit 3.0: accumulate, clamp after the add, then clear
    '{ROW_CFG, CFG_INT_LIM, 23'h00_0300, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{16'sh0200, 16'sh0000, 1'b1}, 1'b1, 16'sd2},
    '{ROW_ITEM, '0, '0, '{16'sh0200, 16'sh0000, 1'b1}, 1'b1, 16'sd3},
    '{ROW_ITEM, '0, '0, '{16'sh0200, 16'sh0000, 1'b1}, 1'b1, 16'sd3},
    '{ROW_ITEM, '0, '0, '{-16'sh0100, 16'sh0000, 1'b1}, 1'b1, 16'sd2},
    '{ROW_ITEM, '0, '0, '{16'sh7FFF, 16'sh0000, 1'b0}, 1'b1, 16'sd0},
    // writes to unused indexes must not disturb anything
    '{ROW_CFG, CFG_INT_LIM, 23'h7F_FFFF, '0, 1'b0, '0},
    '{ROW_CFG, CFG_BAD_LO, 23'h00_0000, '0, 1'b0, '0},
    '{ROW_CFG, CFG_BAD_HI, 23'h7F_FFFF, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{16'sh0100, 16'sh0000, 1'b1}, 1'b1, 16'sd1},
    // all three terms active, checked by the predictor
    '{ROW_CFG, CFG_KP, 23'h00_1234, '0, 1'b0, '0},
    '{ROW_CFG, CFG_KI, 23'h00_7FFF, '0, 1'b0, '0},
    '{ROW_CFG, CFG_KD, 23'h00_8000, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{16'sh1357, -16'sh0321, 1'b1}, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{16'sh8000, 16'sh7FFF, 1'b1}, 1'b0, '0},
    '{ROW_ITEM, '0, '0, '{16'sh7FFF, 16'sh8000, 1'b1}, 1'b0, '0}
  };

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  pac_stream_if #(.payload_t(sample_t)) sample_if ();
  pac_stream_if #(.payload_t(result_t)) result_if ();

  pid_angle_controller_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_if),
    .result    (result_if)
  );

  // Predictor copy of the registers and the integral
  logic signed [GainW-1:0] gain_p, gain_i, gain_d;
  logic [IntLimW-1:0]      int_bound;
  logic [PwmLimW-1:0]      pwm_bound;
  logic signed [IntW-1:0]  integral_acc;

  logic signed [DriveW-1:0] expected_drives [$];
  logic signed [DriveW-1:0] want;
  bit                       failed;
  bit                       calm;         // no idling on either side
  int                       drives_seen;
  int                       stall_left;
  bit                       stall_done;
  int                       cycle_count;

  // Clock
  always #5 clk = ~clk;

  // Advance the integral and work out the drive for one accepted word
  function automatic logic signed [DriveW-1:0] predict_drive(input sample_t s);
    longint err, spd, acc, bound;
    err = longint'(s.angle);
    spd = longint'(s.angular_speed);
    if (s.integrate) begin
      acc   = longint'(integral_acc) + err;
      bound = longint'(int_bound);
      if (acc > bound) acc = bound;
      else if (acc < -bound) acc = -bound;
      integral_acc = IntW'(acc);
    end else begin
      integral_acc = '0;
    end
    // common Q.16 scale, exact sum, clamp, then truncate toward zero
    acc = longint'(gain_p) * err + longint'(gain_i) * longint'(integral_acc)
        + longint'(gain_d) * spd * 256;
    bound = longint'(pwm_bound) << FracShift;
    if (acc > bound) acc = bound;
    else if (acc < -bound) acc = -bound;
    return DriveW'(acc / (longint'(1) << FracShift));
  endfunction

  // Let the pipeline empty out before touching the registers
  task automatic wait_drained();
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write; cfg_we stays high across back-to-back writes
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    if (!cfg_we) begin
      // stop offering the last sample word before draining
      sample_if.valid <= 1'b0;
      wait_drained();
    end
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_KP:      gain_p    = val[GainW-1:0];
      CFG_KI:      gain_i    = val[GainW-1:0];
      CFG_KD:      gain_d    = val[GainW-1:0];
      CFG_INT_LIM: int_bound = val[IntLimW-1:0];
      CFG_PWM_LIM: pwm_bound = val[PwmLimW-1:0];
      default: ;
    endcase
  endtask

  // Offer one sample word, with a random gap ahead of it outside calm phases
  task automatic send_sample(input sample_t s, input bit known,
                             input logic signed [DriveW-1:0] drive);
    logic signed [DriveW-1:0] guess;
    cfg_we <= 1'b0;
    if (!calm) begin
      while ($urandom_range(0, 99) < 34) begin
        sample_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    sample_if.valid <= 1'b1;
    sample_if.data  <= s;
    do @(posedge clk); while (!sample_if.ready);
    guess = predict_drive(s);
    expected_drives.push_back(known ? drive : guess);
  endtask

  // Random gain: extremes, small values, or anything, junk above 16 bits
  function automatic logic [CfgDataW-1:0] pick_gain();
    logic [CfgDataW-1:0] v;
    v = CfgDataW'($urandom);
    case ($urandom_range(0, 5))
      0: v[GainW-1:0] = 16'h7FFF;
      1: v[GainW-1:0] = 16'h8000;
      2: v[GainW-1:0] = 16'h0000;
      3: v[GainW-1:0] = 16'(int'($urandom_range(0, 1023)) - 512);
      default: ;
    endcase
    return v;
  endfunction

  // Result side: check each word, random backpressure, one long hold
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (expected_drives.size() == 0) begin
          $display("%0t: unexpected drive word %0d", $time, result_if.data.drive);
          failed = 1'b1;
        end else begin
          want = expected_drives.pop_front();
          if (result_if.data.drive !== want) begin
            $display("%0t: drive mismatch: expected %0d, actual %0d",
                     $time, want, result_if.data.drive);
            failed = 1'b1;
          end
        end
        drives_seen++;
      end
      if (stall_left != 0) begin
        result_if.ready <= 1'b0;
        stall_left      <= stall_left - 1;
      end else if (drives_seen >= STALL_AT && !stall_done) begin
        result_if.ready <= 1'b0;
        stall_left      <= STALL_CYCLES;
        stall_done      <= 1'b1;
      end else begin
        result_if.ready <= calm || ($urandom_range(0, 99) >= 34);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d drive words outstanding", $time,
               expected_drives.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stimulus
  initial begin
    sample_t s;
    clk             = 1'b0;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    sample_if.valid = 1'b0;
    sample_if.data  = '0;
    result_if.ready = 1'b0;
    failed          = 1'b0;
    calm            = 1'b0;
    drives_seen     = 0;
    stall_left      = 0;
    stall_done      = 1'b0;
    cycle_count     = 0;
    gain_p          = '0;
    gain_i          = '0;
    gain_d          = '0;
    int_bound       = INT_LIM_RESET;
    pwm_bound       = PWM_LIM_RESET;
    integral_acc    = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Scripted part
    for (int r = 0; r < SCRIPT_LEN; r++) begin
      if (SCRIPT[r].kind == ROW_CFG) begin
        write_reg(SCRIPT[r].idx, SCRIPT[r].val);
      end else begin
        send_sample(SCRIPT[r].smp, SCRIPT[r].known, SCRIPT[r].drive);
      end
    end

    // Random phases, each with a fresh register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      calm = (ph == 2);
      write_reg(CFG_KP, pick_gain());
      write_reg(CFG_KI, pick_gain());
      write_reg(CFG_KD, pick_gain());
      case ($urandom_range(0, 3))
        0: write_reg(CFG_INT_LIM, 23'h00_0000);
        1: write_reg(CFG_INT_LIM, 23'h7F_FFFF);
        2: write_reg(CFG_INT_LIM, CfgDataW'($urandom_range(0, 16'h4000)));
        default: write_reg(CFG_INT_LIM, CfgDataW'($urandom));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(CFG_PWM_LIM, {8'($urandom), 15'h0000});
        1: write_reg(CFG_PWM_LIM, {8'($urandom), 15'h7FFF});
        default: write_reg(CFG_PWM_LIM, CfgDataW'($urandom));
      endcase
      if ($urandom_range(0, 1))
        write_reg(CFG_PWM_LIM + CfgIdxW'($urandom_range(1, 3)), CfgDataW'($urandom));

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender waits for everything outstanding once mid-run
        if (ph == 4 && n == PHASE_ITEMS / 2) begin
          sample_if.valid <= 1'b0;
          while (expected_drives.size() != 0) @(posedge clk);
        end
        s.angle         = $urandom_range(0, 1) ? 16'($urandom)
                                               : 16'(int'($urandom_range(0, 2047)) - 1024);
        s.angular_speed = $urandom_range(0, 1) ? 16'($urandom)
                                               : 16'(int'($urandom_range(0, 511)) - 256);
        s.integrate     = ($urandom_range(0, 99) < 85);
        send_sample(s, 1'b0, '0);
      end
    end
    calm = 1'b0;
    sample_if.valid <= 1'b0;

    // Drain and look for stray words
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
src/pac_pkg.sv
src/pac_stream_if.sv
src/pid_angle_controller_top.sv
src/pac_checker.sv
bench/tb_pid_angle_controller_top.sv
